// ----- rtl/bfa_pkg.sv -----
package bfa_pkg;

  // Map geometry: one bit per 4 KiB frame, 32 frames per map word.
  localparam int FRAMES     = 32768;
  localparam int FRAME_BITS = $clog2(FRAMES);
  localparam int WORD_BITS  = 5;
  localparam int MAP_WORDS  = FRAMES / 32;
  localparam int MAP_AW     = FRAME_BITS - WORD_BITS;
  localparam int PAGE_SHIFT = 12;
  localparam int FADDR_W    = 27;

  // Frame indexes computed from 33-bit byte sums.
  localparam int SUM_FW = 33 - PAGE_SHIFT;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REGION = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFRAME = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] REG_KERNEL_END  = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;
    logic take;
    logic prep1;
    logic prep2;
    logic issue;
    logic proc;
    logic load_out;
  } bfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic ptr_last;
    logic proc_last;
    logic found;
    logic empty;
  } bfa_sts_t;

endpackage

// ----- rtl/bfa_ctrl.sv -----
module bfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bfa_pkg::bfa_sts_t sts,
  output bfa_pkg::bfa_cmd_t cmd
);
  import bfa_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PREP1  = 3'd2;
  localparam logic [2:0] S_PREP2  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       dv;
  logic       issued_done;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Command decode and next state.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = accept;
        if (accept) begin
          state_next = S_PREP1;
        end
      end
      S_PREP1: begin
        cmd.prep1  = 1'b1;
        state_next = S_PREP2;
      end
      S_PREP2: begin
        cmd.prep2  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.issue = !issued_done;
          cmd.proc  = dv;
          if (dv && (sts.proc_last || sts.found)) begin
            cmd.issue  = 1'b0;
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      dv          <= 1'b0;
      issued_done <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= cmd.issue;
      if (cmd.prep2) begin
        issued_done <= 1'b0;
      end else if (cmd.issue && sts.ptr_last) begin
        issued_done <= 1'b1;
      end
    end
  end

  // The output register holds its transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/bfa_datapath.sv -----
module bfa_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  bfa_pkg::bfa_cmd_t               cmd,
  output bfa_pkg::bfa_sts_t               sts,
  input  logic [1:0]                      op,
  input  logic [31:0]                     address,
  input  logic [31:0]                     length,
  input  logic                            cfg_valid,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic [bfa_pkg::FADDR_W-1:0]     frame_address,
  output logic [1:0]                      status
);
  import bfa_pkg::*;

  localparam logic [SUM_FW-1:0] FRAMES_F = SUM_FW'(FRAMES);

  // Lowest set bit position of a nonzero word.
  function automatic logic [WORD_BITS-1:0] low_index(input logic [31:0] v);
    logic [WORD_BITS-1:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_BITS'(i);
      end
    end
    return idx;
  endfunction

  logic [31:0]           mem [MAP_WORDS];
  logic [31:0]           rd_data;
  logic [MAP_AW-1:0]     rd_w;
  logic [MAP_AW-1:0]     ptr;
  logic [15:0]           frame_total;
  logic [FRAME_BITS-1:0] kernel_end;
  logic [1:0]            op_r;
  logic [31:0]           addr_r;
  logic [31:0]           len_r;
  logic [SUM_FW-1:0]     first_r;
  logic [SUM_FW-1:0]     last_r;
  logic [FRAME_BITS-1:0] lo_r;
  logic [FRAME_BITS-1:0] hm1_r;
  logic                  empty_r;
  logic [FRAME_BITS-1:0] res_frame;
  logic [1:0]            res_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= '0;
      kernel_end  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_total <= cfg_data;
        REG_KERNEL_END:  kernel_end  <= cfg_data[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // First stage: frame range [first, last) of the transaction.
  logic [32:0]       sum_base;
  logic [32:0]       sum_end;
  logic [15:0]       limit;
  logic [SUM_FW-1:0] first_next;
  logic [SUM_FW-1:0] last_next;

  always_comb begin
    sum_base = {1'b0, addr_r} + 33'd4095;
    sum_end  = {1'b0, addr_r} + {1'b0, len_r};
    limit    = (frame_total > 16'(FRAMES)) ? 16'(FRAMES) : frame_total;
    case (op_r)
      OP_ALLOC: begin
        first_next = '0;
        last_next  = SUM_FW'(limit);
      end
      OP_FREE: begin
        first_next = SUM_FW'(addr_r[31:PAGE_SHIFT]);
        last_next  = SUM_FW'(addr_r[31:PAGE_SHIFT]) + SUM_FW'(1);
      end
      OP_REGION: begin
        first_next = sum_base[32:PAGE_SHIFT];
        last_next  = sum_end[32:PAGE_SHIFT];
      end
      default: begin
        first_next = '0;
        last_next  = '0;
      end
    endcase
  end

  // Second stage: clip to capacity and, for frees and regions, lift above the kernel frames.
  logic [SUM_FW-1:0] kend_p1;
  logic [SUM_FW-1:0] lo_next;
  logic [SUM_FW-1:0] hi_next;
  logic [SUM_FW-1:0] hm1_next;
  logic              beyond;

  always_comb begin
    kend_p1 = SUM_FW'(kernel_end) + SUM_FW'(1);
    if (op_r != OP_ALLOC && first_r <= SUM_FW'(kernel_end)) begin
      lo_next = kend_p1;
    end else begin
      lo_next = first_r;
    end
    hi_next  = (last_r > FRAMES_F) ? FRAMES_F : last_r;
    hm1_next = hi_next - SUM_FW'(1);
    beyond   = (last_r > first_r) && (last_r > FRAMES_F);
  end

  // Per-word mask of the frames inside the range.
  logic [WORD_BITS-1:0] lo_b;
  logic [WORD_BITS-1:0] hi_b;
  logic [31:0]          mask;
  logic [31:0]          cand;
  logic [31:0]          low_bit;
  logic [31:0]          wr_word;

  always_comb begin
    lo_b    = (rd_w == lo_r[FRAME_BITS-1:WORD_BITS]) ? lo_r[WORD_BITS-1:0] : '0;
    hi_b    = (rd_w == hm1_r[FRAME_BITS-1:WORD_BITS]) ? hm1_r[WORD_BITS-1:0] : '1;
    mask    = ({32{1'b1}} << lo_b) & ({32{1'b1}} >> (~hi_b));
    cand    = ~rd_data & mask;
    low_bit = cand & (~cand + 32'd1);
    if (op_r == OP_ALLOC) begin
      wr_word = rd_data | low_bit;
    end else begin
      wr_word = rd_data & ~mask;
    end
  end

  assign sts.init_last = (ptr == MAP_AW'(MAP_WORDS - 1));
  assign sts.ptr_last  = (ptr == hm1_r[FRAME_BITS-1:WORD_BITS]);
  assign sts.proc_last = (rd_w == hm1_r[FRAME_BITS-1:WORD_BITS]);
  assign sts.found     = (op_r == OP_ALLOC) && (cand != '0);
  assign sts.empty     = empty_r;

  // Frame map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      mem[ptr] <= '1;
    end else if (cmd.proc && (op_r != OP_ALLOC || cand != '0)) begin
      mem[rd_w] <= wr_word;
    end
    if (cmd.issue) begin
      rd_data <= mem[ptr];
    end
  end

  // Word pointer for the clearing pass and the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.init_wr || cmd.issue) begin
      ptr <= ptr + MAP_AW'(1);
    end else if (cmd.prep2) begin
      ptr <= lo_next[FRAME_BITS-1:WORD_BITS];
    end
  end

  // Transaction registers and result.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_w <= ptr;
    end
    if (cmd.take) begin
      op_r   <= op;
      addr_r <= address;
      len_r  <= length;
    end
    if (cmd.prep1) begin
      first_r <= first_next;
      last_r  <= last_next;
    end
    if (cmd.prep2) begin
      lo_r      <= lo_next[FRAME_BITS-1:0];
      hm1_r     <= hm1_next[FRAME_BITS-1:0];
      empty_r   <= (lo_next >= hi_next);
      res_frame <= '0;
      if (op_r == OP_ALLOC) begin
        res_status <= ST_NOFRAME;
      end else if (beyond) begin
        res_status <= ST_BEYOND;
      end else begin
        res_status <= ST_OK;
      end
    end else if (cmd.proc && sts.found) begin
      res_frame  <= {rd_w, low_index(cand)};
      res_status <= ST_OK;
    end
    if (cmd.load_out) begin
      frame_address <= FADDR_W'({res_frame, {PAGE_SHIFT{1'b0}}});
      status        <= res_status;
    end
  end

endmodule

// ----- rtl/bitmap_frame_allocator.sv -----
// Bitmap page frame allocator, one map bit per 4 KiB frame (1 = used).
// Input channel (in_valid/in_stall) carries op, address and length; an
// alloc returns the lowest free frame below the configured frame total, a
// free clears one frame, a region frees the whole frames of
// [address, address + length). Frames up to the last reserved kernel frame
// are never freed. Every input transaction gives one output transaction
// (frame_address, status) on out_valid/out_stall.
// Configuration writes use cfg_valid/cfg_ready with cfg_index 0 for the
// frame total and 1 for the last kernel frame; cfg_ready is always high and
// writes are meant only while the block is idle.
// Sequence: each item passes the input capture, PREP1 and PREP2, then a scan
// of the map words with a registered memory read, then a load of the output
// register; the scan goes through the single read port of the 1024-word
// map. Items are handled one at a time; the next is accepted as soon as the
// previous result sits in the output register.
// After reset a clearing pass writes all 1024 map words to all ones, with
// in_stall high. A stalled output holds its transaction; a finished result
// then waits internally and in_stall stays high.
module bitmap_frame_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [31:0]                 address,
  input  logic [31:0]                 length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfa_pkg::FADDR_W-1:0] frame_address,
  output logic [1:0]                  status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);
  import bfa_pkg::*;

  bfa_cmd_t cmd;
  bfa_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer for setup, scan and output.
  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Frame map, range arithmetic and result registers.
  bfa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .address       (address),
    .length        (length),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .frame_address (frame_address),
    .status        (status)
  );

endmodule
